// ----- design/bte_pkg.sv -----
// Shared types, codes and character functions of the text encoder.
`default_nettype none

package bte_pkg;

  // Output encoding selected by the mode register.
  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_B64  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  localparam int unsigned MaxChars  = 4;
  localparam int unsigned CharIdxW  = $clog2(MaxChars);
  localparam logic [7:0]  PadChar   = 8'h3D;  // '='

  // One encoded item: up to four characters, index of the final one,
  // and whether the final one closes the buffer.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CharIdxW-1:0]      last_idx;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'b0, nib};
    end else begin
      c = 8'h61 + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b0, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b0, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b0, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/bte_if.sv -----
// Channel interfaces of the text encoder: byte input, character output, mode write.
`default_nettype none

interface bte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;
  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

interface bte_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ----- design/bte_front.sv -----
// Front end: accepts bytes, tracks the base64 group and builds encoded jobs.
`default_nettype none

module bte_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bte_pkg::mode_e     mode_i,
  bte_byte_if.sink                byte_i,
  input  wire bte_pkg::queue_stat_t q_stat_i,
  output logic                    push_o,
  output bte_pkg::job_t           job_o
);
  import bte_pkg::*;

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhOne   = 2'd1;
  localparam logic [1:0] PhTwo   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;
  logic       accept;

  assign byte_i.ready = ~q_stat_i.full;
  assign accept       = byte_i.valid & ~q_stat_i.full;
  assign push_o       = accept;
  assign b            = byte_i.data_byte;

  always_comb begin
    job_o          = '0;
    job_o.last     = byte_i.last_byte;
    phase_d        = phase_q;
    left_d         = left_q;
    case (mode_i)
      MODE_HEX: begin
        job_o.chars[0] = hex_char(b[7:4]);
        job_o.chars[1] = hex_char(b[3:0]);
        job_o.last_idx = CharIdxW'(1);
      end
      MODE_B64: begin
        case (phase_q)
          PhOne: begin
            job_o.chars[0] = b64_char({left_q[1:0], b[7:4]});
            if (byte_i.last_byte) begin
              job_o.chars[1] = b64_char({b[3:0], 2'b00});
              job_o.chars[2] = PadChar;
              job_o.last_idx = CharIdxW'(2);
              phase_d        = PhStart;
              left_d         = '0;
            end else begin
              phase_d = PhTwo;
              left_d  = b[3:0];
            end
          end
          PhTwo: begin
            job_o.chars[0] = b64_char({left_q, b[7:6]});
            job_o.chars[1] = b64_char(b[5:0]);
            job_o.last_idx = CharIdxW'(1);
            phase_d        = PhStart;
            left_d         = '0;
          end
          default: begin
            job_o.chars[0] = b64_char(b[7:2]);
            if (byte_i.last_byte) begin
              job_o.chars[1] = b64_char({b[1:0], 4'b0000});
              job_o.chars[2] = PadChar;
              job_o.chars[3] = PadChar;
              job_o.last_idx = CharIdxW'(3);
              phase_d        = PhStart;
              left_d         = '0;
            end else begin
              phase_d = PhOne;
              left_d  = {2'b00, b[1:0]};
            end
          end
        endcase
      end
      default: begin
        job_o.chars[0] = b;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/bte_queue.sv -----
// Two-entry job queue between the front and back ends.
`default_nettype none

module bte_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire bte_pkg::job_t        job_i,
  input  wire logic                 pop_i,
  output bte_pkg::job_t             job_o,
  output bte_pkg::queue_stat_t      stat_o
);
  import bte_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign job_o        = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/bte_back.sv -----
// Back end: walks each queued job and sends one character per cycle while the output is ready.
`default_nettype none

module bte_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bte_pkg::queue_stat_t q_stat_i,
  input  wire bte_pkg::job_t        job_i,
  output logic                      pop_o,
  bte_char_if.source                char_o
);
  import bte_pkg::*;

  logic [CharIdxW-1:0] idx_q;
  logic                valid_q;
  logic [7:0]          char_q;
  logic                last_q;
  logic                load;
  logic                at_end;

  assign load   = ~q_stat_i.empty & (~valid_q | char_o.ready);
  assign at_end = (idx_q == job_i.last_idx);
  assign pop_o  = load & at_end;

  assign char_o.valid     = valid_q;
  assign char_o.char_out  = char_q;
  assign char_o.last_char = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= job_i.chars[idx_q];
      last_q <= job_i.last & at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? '0 : idx_q + CharIdxW'(1);
      end else if (char_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/buffer_text_encoder.sv -----
// A taken byte's job goes into the queue, then its first character into the output register.
// The back end sends one character per cycle while the output is ready; characters per item:
//   raw 1, hex 2, base64 1 or 2 mid-group and up to 4 on the final byte (group padding).
// Input back-pressure comes only from the two-entry job queue filling up.
// Reset (rst_ni low, async) clears the mode to raw, the base64 group state,
//   the queue and the output valid flag.
`default_nettype none

module buffer_text_encoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bte_byte_if.sink   byte_i,
  bte_cfg_if.sink    cfg_i,
  bte_char_if.source char_o
);
  import bte_pkg::*;

  // Mode register: the user must write it only while the encoder is idle; the block does not enforce it.
  mode_e       mode_q;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;
  queue_stat_t q_stat;

  // Always take mode writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAW;
    end else if (cfg_i.valid) begin
      mode_q <= mode_e'(cfg_i.mode);
    end
  end

  // Front end: classify each byte under the mode and build its whole
  // character list in the same cycle, advancing the base64 group state.
  bte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode_q),
    .byte_i   (byte_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Short queue decouples byte intake from character output.
  bte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  // Back end: drain the head job one character per cycle, while the output is ready,
  // into the output register; pop the job with its final character.
  bte_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .job_i    (head_job),
    .pop_o    (pop),
    .char_o   (char_o)
  );

endmodule

`default_nettype wire

// ----- design/bte_checker.sv -----
// Port-level checker for the text encoder, bound to the top level.
`default_nettype none

module bte_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       byte_valid,
  input wire logic       byte_ready,
  input wire logic       cfg_ready,
  input wire logic       char_valid,
  input wire logic       char_ready,
  input wire logic [7:0] char_out,
  input wire logic       char_last
);

  // Stalled output keeps its character.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid && !char_ready |=> char_valid && $stable(char_out) && $stable(char_last))
    else $error("output item changed while stalled");

  // Input back-pressure only happens with output work pending.
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid && !byte_ready |-> char_valid)
    else $error("input stalled with no output pending");

  // Mode writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("mode write port not ready");

  // Nothing is offered in the cycle after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !char_valid)
    else $error("output valid after reset");

endmodule

bind buffer_text_encoder bte_checker u_bte_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .byte_valid (byte_i.valid),
  .byte_ready (byte_i.ready),
  .cfg_ready  (cfg_i.ready),
  .char_valid (char_o.valid),
  .char_ready (char_o.ready),
  .char_out   (char_o.char_out),
  .char_last  (char_o.last_char)
);

`default_nettype wire

// ----- dv/buffer_text_encoder_tb.sv -----
// Self-checking testbench of the raw, hex and base64 text encoder.
`timescale 1ns / 100ps

module buffer_text_encoder_tb;
  import bte_pkg::*;

  localparam int unsigned IdleLimit = 1000;  // cycles with no handshake at all
  localparam int unsigned NumRandom = 128;
  localparam int unsigned ShowMax   = 10;

  // Character tables of the two encodings, first character in the top byte.
  localparam logic [8*16-1:0] HexTab = "0123456789abcdef";
  localparam logic [8*64-1:0] B64Tab =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0] PadSym = "=";

  // One emitted character as it should leave the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Characters typed in by hand for one item; count 0 leaves it to the predictor.
  typedef struct packed {
    logic [2:0]       count;
    logic [0:3][7:0]  chars;
  } typed_t;

  typedef struct {
    mode_e      mode;
    logic [7:0] data;
    logic       last;
    typed_t     hint;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bte_byte_if byte_if ();
  bte_cfg_if  cfg_if ();
  bte_char_if char_if ();

  buffer_text_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cfg_i  (cfg_if),
    .char_o (char_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: its own copy of the mode and of the base64 group.
  mode_e      enc_mode   = MODE_RAW;
  logic [1:0] grp_phase  = 2'd0;
  logic [3:0] carry_bits = 4'd0;

  logic [7:0] step_chars[$];      // characters that the last byte produced
  enc_char_t  expected_chars[$];  // characters still owed by the block
  typed_t     typed_chars[$];     // one entry per byte sent, in send order

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;  // set: neither side idles
  mode_e       drv_mode    = MODE_RAW;  // mode last written by the stimulus

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HexTab[8*(15 - int'(nib)) +: 8];
  endfunction

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    return B64Tab[8*(63 - int'(v)) +: 8];
  endfunction

  // Compute the characters that one byte completes and advance the group state.
  // Raw, hex and the reserved mode leave the base64 group untouched.
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    step_chars.delete();
    case (enc_mode)
      MODE_HEX: begin
        step_chars.push_back(hex_digit(b[7:4]));
        step_chars.push_back(hex_digit(b[3:0]));
      end
      MODE_B64: begin
        case (grp_phase)
          2'd1: begin
            step_chars.push_back(b64_sym({carry_bits[1:0], b[7:4]}));
            if (last) begin
              // Two bytes in the group: one symbol from the tail, one pad.
              step_chars.push_back(b64_sym({b[3:0], 2'b00}));
              step_chars.push_back(PadSym);
              grp_phase  = 2'd0;
              carry_bits = 4'd0;
            end else begin
              carry_bits = b[3:0];
              grp_phase  = 2'd2;
            end
          end
          2'd2: begin
            // Third byte closes the group, last or not.
            step_chars.push_back(b64_sym({carry_bits, b[7:6]}));
            step_chars.push_back(b64_sym(b[5:0]));
            grp_phase  = 2'd0;
            carry_bits = 4'd0;
          end
          default: begin
            // Phase three cannot arise; it falls in here as a fresh group.
            step_chars.push_back(b64_sym(b[7:2]));
            if (last) begin
              step_chars.push_back(b64_sym({b[1:0], 4'b0000}));
              step_chars.push_back(PadSym);
              step_chars.push_back(PadSym);
              grp_phase  = 2'd0;
              carry_bits = 4'd0;
            end else begin
              carry_bits = {2'b00, b[1:0]};
              grp_phase  = 2'd1;
            end
          end
        endcase
      end
      default: step_chars.push_back(b);  // raw, and the reserved mode acts as raw
    endcase
  endfunction

  // Track every handshake: mode writes and bytes feed the predictor, characters
  // are checked against the oldest expectation. Push before pop in one block.
  always @(posedge clk_i) begin : scoreboard
    typed_t    hint;
    enc_char_t got;
    enc_char_t want;
    int        n;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        enc_mode = mode_e'(cfg_if.mode);
      end
      if (byte_if.valid && byte_if.ready) begin
        encode_byte(byte_if.data_byte, byte_if.last_byte);
        hint = typed_chars.pop_front();
        // Only the final character of a final byte carries the last mark.
        if (hint.count != 0) begin
          n = hint.count;
          for (int k = 0; k < n; k++) begin
            expected_chars.push_back('{hint.chars[k], byte_if.last_byte && k == n - 1});
          end
        end else begin
          n = step_chars.size();
          for (int k = 0; k < n; k++) begin
            expected_chars.push_back('{step_chars[k], byte_if.last_byte && k == n - 1});
          end
        end
      end
      if (char_if.valid && char_if.ready) begin
        got = '{char_if.char_out, char_if.last_char};
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= ShowMax) begin
            $display("%0t: unexpected char %02h last %0b", $time, got.ch, got.last);
          end
        end else begin
          want = expected_chars.pop_front();
          if (got.ch !== want.ch || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= ShowMax) begin
              $display("%0t: char expected %02h got %02h, last expected %0b got %0b",
                       $time, want.ch, got.ch, want.last, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run once no channel has moved anything for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (char_if.valid && char_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("buffer_text_encoder_tb failed");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Character sink: draw a stall per character, then hold ready until one is taken.
  initial begin : char_sink
    int unsigned gap;
    char_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        char_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      char_if.ready <= 1'b1;
      do @(posedge clk_i); while (!char_if.valid);
    end
  end

  // Offer one byte after a random gap and return at the edge that takes it.
  task automatic send_byte(input logic [7:0] data, input logic last, input typed_t hint);
    int unsigned gap;
    typed_chars.push_back(hint);
    gap = draw_gap();
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= data;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  // Stop sending and wait until every owed character is out.
  task automatic settle();
    byte_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the mode register; call only while the block is idle.
  task automatic write_mode(input mode_e m);
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    drv_mode = m;
  endtask

  function automatic mode_e pick_mode();
    case ($urandom_range(0, 6))
      3:       return MODE_RAW;
      4:       return MODE_HEX;
      5:       return MODE_RSVD;
      default: return MODE_B64;
    endcase
  endfunction

  // Directed items. Characters are typed in where obvious; count 0 rows are
  // left to the predictor.
  dir_row_t dir_rows [0:22] = '{
    // raw extremes
    '{MODE_RAW,  8'h00, 1'b0, '{3'd1, {8'h00, 24'h0}}},
    '{MODE_RAW,  8'hFF, 1'b1, '{3'd1, {8'hFF, 24'h0}}},
    '{MODE_RAW,  8'h41, 1'b0, '{3'd0, 32'h0}},
    // hex extremes and a mixed nibble pair
    '{MODE_HEX,  8'h00, 1'b0, '{3'd2, {"00", 16'h0}}},
    '{MODE_HEX,  8'hFF, 1'b1, '{3'd2, {"ff", 16'h0}}},
    '{MODE_HEX,  8'hA5, 1'b0, '{3'd2, {"a5", 16'h0}}},
    '{MODE_HEX,  8'h3C, 1'b1, '{3'd0, 32'h0}},
    // base64: one-byte buffers with double pad
    '{MODE_B64,  8'h00, 1'b1, '{3'd4, "AA=="}},
    '{MODE_B64,  8'hFF, 1'b1, '{3'd4, "/w=="}},
    // a full group with no pad
    '{MODE_B64,  8'h4D, 1'b0, '{3'd1, {"T", 24'h0}}},
    '{MODE_B64,  8'h61, 1'b0, '{3'd1, {"W", 24'h0}}},
    '{MODE_B64,  8'h6E, 1'b1, '{3'd2, {"Fu", 16'h0}}},
    // two-byte buffer with single pad
    '{MODE_B64,  8'hFF, 1'b0, '{3'd1, {"/", 24'h0}}},
    '{MODE_B64,  8'hFF, 1'b1, '{3'd3, {"/8=", 8'h0}}},
    // a group closed without the last mark
    '{MODE_B64,  8'h00, 1'b0, '{3'd0, 32'h0}},
    '{MODE_B64,  8'h00, 1'b0, '{3'd0, 32'h0}},
    '{MODE_B64,  8'h00, 1'b0, '{3'd0, 32'h0}},
    // leave a group open, switch away through hex, raw and the reserved mode,
    // then come back: the open group must resume where it stopped
    '{MODE_B64,  8'h12, 1'b0, '{3'd0, 32'h0}},
    '{MODE_HEX,  8'h9B, 1'b0, '{3'd2, {"9b", 16'h0}}},
    '{MODE_RAW,  8'h7E, 1'b0, '{3'd0, 32'h0}},
    '{MODE_RSVD, 8'h80, 1'b1, '{3'd1, {8'h80, 24'h0}}},
    '{MODE_B64,  8'h34, 1'b0, '{3'd0, 32'h0}},
    '{MODE_B64,  8'h56, 1'b1, '{3'd0, 32'h0}}
  };

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned buf_len;
    int unsigned taken;
    int unsigned bufs;
    bit          paused;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.last_byte = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.mode       = MODE_RAW;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: write the mode only when a row asks for another one.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != drv_mode) begin
        settle();
        write_mode(dir_rows[i].mode);
      end
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].hint);
    end

    // Random part: phases of one mode each, filled with buffers of random
    // length that end on a last byte. A phase may stop mid-buffer, so the
    // next phase can start with a base64 group still open.
    sent   = 0;
    paused = 1'b0;
    while (sent < NumRandom) begin
      settle();
      calm = 1'b0;
      write_mode(pick_mode());
      calm      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 24);
      taken     = 0;
      bufs      = 0;
      while (taken < phase_len) begin
        buf_len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        for (int j = 0; j < buf_len && taken < phase_len; j++) begin
          send_byte(8'($urandom_range(0, 255)), j == buf_len - 1, '{3'd0, 32'h0});
          taken++;
          sent++;
        end
        bufs++;
        // Hold the sender until the block has emptied, at least once per run.
        if (bufs == 1 && (!paused || $urandom_range(0, 2) == 0)) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("buffer_text_encoder_tb passed");
    end else begin
      $display("buffer_text_encoder_tb failed");
    end
    $finish;
  end

endmodule

// ----- buffer_text_encoder.f -----
design/bte_pkg.sv
design/bte_if.sv
design/bte_front.sv
design/bte_queue.sv
design/bte_back.sv
design/buffer_text_encoder.sv
design/bte_checker.sv
dv/buffer_text_encoder_tb.sv
